### hdl/uer_pkg.sv
// uer_pkg: shared types, register indexes and constants of the echo ranger
// no dependencies; used by the channel interfaces and every module
`timescale 1ns / 1ps
`default_nettype none
package uer_pkg;

  localparam int WIDTH_BITS_DEFAULT = 16;

  localparam int IntervalW = 24;
  localparam int TrigW     = 8;
  localparam int TimeoutW  = 16;
  localparam int DivisorW  = 8;
  localparam int OffsetW   = 8;
  localparam int DistW     = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;

  // width plus offset needs one bit more than the width counter
  localparam int DividendW = TimeoutW + 1;
  localparam int DivSteps  = DividendW;
  localparam int DivCntW   = $clog2(DivSteps + 1);

  localparam logic [CfgIdxW-1:0] REG_INTERVAL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_START_TO  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ECHO_TO   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_ECHO  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ROUND     = 3'd6;

  localparam logic [IntervalW-1:0] RST_INTERVAL = 24'd50000;
  localparam logic [TrigW-1:0]     RST_TRIGGER  = 8'd10;
  localparam logic [TimeoutW-1:0]  RST_START_TO = 16'd1000;
  localparam logic [TimeoutW-1:0]  RST_ECHO_TO  = 16'd30000;
  localparam logic [TimeoutW-1:0]  RST_MIN_ECHO = 16'd2;
  localparam logic [DivisorW-1:0]  RST_DIVISOR  = 8'd58;
  localparam logic [OffsetW-1:0]   RST_ROUND    = 8'd29;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_STUCK   = 2'd1,
    ST_NOSTART = 2'd2,
    ST_SHORT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRIG  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  typedef enum logic {
    CTL_IDLE   = 1'b0,
    CTL_DIVIDE = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic tick;
    logic div_start;
    logic load_div;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_done;
  } dp_status_t;

endpackage
`default_nettype wire

### hdl/uer_channels.sv
// uer_channels: valid/ready channel interfaces for echo ticks and results
// depends on uer_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none
interface uer_echo_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface uer_result_if;
  logic                      valid;
  logic                      ready;
  logic                      trigger_level;
  logic                      measurement_done;
  logic [1:0]                status;
  logic [uer_pkg::DistW-1:0] distance_cm;

  modport source (output valid, output trigger_level, output measurement_done,
                  output status, output distance_cm, input ready);
  modport sink (input valid, input trigger_level, input measurement_done,
                input status, input distance_cm, output ready);
endinterface
`default_nettype wire

### hdl/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: top level, one result transaction per echo tick
// depends on uer_pkg, uer_channels, uer_ctrl, uer_datapath, uer_divider
//
//   port        dir  protocol     carries
//   echo_in     in   valid/ready  echo_level, one per microsecond tick
//   result_out  out  valid/ready  trigger_level, measurement_done, status, distance_cm
//   cfg_*       in   write only   cfg_we, cfg_index, cfg_data
//
// for most ticks the result is registered at the accepting edge
// a tick that ends a valid echo also waits for the 17 steps of the serial
// divider and then the load of the held distance
// one tick is in flight at a time; a stalled result holds the next tick off
// synchronous reset restores register defaults and starts measuring at once
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_echo_ranger #(
  parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  uer_echo_if.sink                          echo_in,
  uer_result_if.source                      result_out,
  input  wire logic                         cfg_we,
  input  wire logic [uer_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [uer_pkg::CfgDataW-1:0] cfg_data
);
  import uer_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t stat;
  logic       in_ready;
  logic       out_valid;
  logic [1:0] status;

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (echo_in.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  uer_datapath #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .echo_level       (echo_in.echo_level),
    .cmd              (cmd),
    .stat             (stat),
    .trigger_level    (result_out.trigger_level),
    .measurement_done (result_out.measurement_done),
    .status           (status),
    .distance_cm      (result_out.distance_cm)
  );

  assign echo_in.ready     = in_ready;
  assign result_out.valid  = out_valid;
  assign result_out.status = status;
endmodule
`default_nettype wire

### hdl/uer_divider.sv
// uer_divider: restoring divider, one quotient bit per cycle
// depends on uer_pkg; divisor zero gives an all-ones quotient
`timescale 1ns / 1ps
`default_nettype none
module uer_divider (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [uer_pkg::DividendW-1:0] dividend,
  input  wire logic [uer_pkg::DivisorW-1:0]  divisor,
  output logic      [uer_pkg::DividendW-1:0] quotient,
  output logic                              done
);
  import uer_pkg::*;

  logic [DivCntW-1:0]   cnt;
  logic [DivisorW-1:0]  rem;
  logic [DivisorW-1:0]  dvs;
  logic [DividendW-1:0] quo;
  logic [DivisorW:0]    rem_sh;
  logic                 fits;

  assign rem_sh = {rem, quo[DividendW-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= DivCntW'(DivSteps);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      // remainder stays below the divisor, so the low bits are enough
      rem <= fits ? DivisorW'(rem_sh - {1'b0, dvs}) : rem_sh[DivisorW-1:0];
      quo <= {quo[DividendW-2:0], fits};
    end
  end

  assign quotient = quo;
endmodule
`default_nettype wire

### hdl/uer_datapath.sv
// uer_datapath: config registers, tick counters, phase logic and distance
// depends on uer_pkg and uer_divider; driven by uer_ctrl commands
`timescale 1ns / 1ps
`default_nettype none
module uer_datapath #(
  parameter int WIDTH_BITS = uer_pkg::WIDTH_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [uer_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [uer_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                         echo_level,
  input  wire uer_pkg::ctl_cmd_t            cmd,
  output uer_pkg::dp_status_t               stat,
  output logic                              trigger_level,
  output logic                              measurement_done,
  output logic [1:0]                        status,
  output logic [uer_pkg::DistW-1:0]         distance_cm
);
  import uer_pkg::*;

  localparam logic [DistW-1:0] DistLimit =
    (WIDTH_BITS >= DistW) ? {DistW{1'b1}} : DistW'((1 << WIDTH_BITS) - 1);

  logic [IntervalW-1:0] interval_ticks;
  logic [TrigW-1:0]     trigger_ticks;
  logic [TimeoutW-1:0]  start_timeout;
  logic [TimeoutW-1:0]  echo_timeout;
  logic [TimeoutW-1:0]  min_valid_echo;
  logic [DivisorW-1:0]  scale_divisor;
  logic [OffsetW-1:0]   round_offset;

  phase_t               phase, phase_next;
  logic [IntervalW-1:0] interval_count, interval_count_next, interval_dec;
  logic [TimeoutW-1:0]  phase_count, phase_count_next;
  logic [TimeoutW-1:0]  echo_width, echo_width_next;
  logic [DistW-1:0]     held_distance;
  logic                 trig_t, done_t, needs_div;
  status_t              status_t_val;
  logic                 wait_step;

  logic [DividendW-1:0] dividend;
  logic [DividendW-1:0] quotient;
  logic                 div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= RST_INTERVAL;
      trigger_ticks  <= RST_TRIGGER;
      start_timeout  <= RST_START_TO;
      echo_timeout   <= RST_ECHO_TO;
      min_valid_echo <= RST_MIN_ECHO;
      scale_divisor  <= RST_DIVISOR;
      round_offset   <= RST_ROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INTERVAL: interval_ticks <= cfg_data[IntervalW-1:0];
        REG_TRIGGER:  trigger_ticks  <= cfg_data[TrigW-1:0];
        REG_START_TO: start_timeout  <= cfg_data[TimeoutW-1:0];
        REG_ECHO_TO:  echo_timeout   <= cfg_data[TimeoutW-1:0];
        REG_MIN_ECHO: min_valid_echo <= cfg_data[TimeoutW-1:0];
        REG_DIVISOR:  scale_divisor  <= cfg_data[DivisorW-1:0];
        REG_ROUND:    round_offset   <= cfg_data[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  assign interval_dec = (interval_count != '0) ? interval_count - 1'b1 : interval_count;

  always_comb begin
    phase_next          = phase;
    interval_count_next = interval_dec;
    phase_count_next    = phase_count;
    echo_width_next     = echo_width;
    trig_t              = 1'b0;
    done_t              = 1'b0;
    needs_div           = 1'b0;
    status_t_val        = ST_VALID;
    wait_step           = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (interval_dec == '0) begin
          interval_count_next = interval_ticks;
          if (echo_level) begin
            done_t       = 1'b1;
            status_t_val = ST_STUCK;
          end else begin
            trig_t           = 1'b1;
            phase_next       = PH_TRIG;
            phase_count_next = TimeoutW'(1);
          end
        end
      end
      PH_TRIG: begin
        if (phase_count < {{(TimeoutW-TrigW){1'b0}}, trigger_ticks}) begin
          trig_t           = 1'b1;
          phase_count_next = phase_count + 1'b1;
        end else begin
          phase_next = PH_WAIT;
          wait_step  = 1'b1;
        end
      end
      PH_WAIT: wait_step = 1'b1;
      PH_COUNT: begin
        if (echo_level && echo_width < echo_timeout) begin
          echo_width_next = echo_width + 1'b1;
        end else begin
          done_t     = 1'b1;
          phase_next = PH_IDLE;
          if (echo_width <= min_valid_echo) begin
            status_t_val = ST_SHORT;
          end else begin
            needs_div = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // trigger end falls through into the first wait tick
    if (wait_step) begin
      if (echo_level) begin
        phase_next      = PH_COUNT;
        echo_width_next = TimeoutW'(1);
      end else if (phase_count >= start_timeout) begin
        done_t       = 1'b1;
        status_t_val = ST_NOSTART;
        phase_next   = PH_IDLE;
      end else begin
        phase_count_next = phase_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      interval_count <= '0;
      phase_count    <= '0;
      echo_width     <= '0;
      held_distance  <= '0;
    end else begin
      if (cmd.tick) begin
        phase          <= phase_next;
        interval_count <= interval_count_next;
        phase_count    <= phase_count_next;
        echo_width     <= echo_width_next;
      end
      if (cmd.load_div) begin
        held_distance <= (quotient > {1'b0, DistLimit}) ? DistLimit
                                                        : quotient[DistW-1:0];
      end
    end
  end

  // result fields of the transaction; distance follows the held value
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      trigger_level    <= trig_t;
      measurement_done <= done_t;
      status           <= status_t_val;
    end
  end

  assign distance_cm = held_distance;

  assign dividend = {1'b0, echo_width} + {{(DividendW-OffsetW){1'b0}}, round_offset};

  uer_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (scale_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  assign stat.needs_div = needs_div;
  assign stat.div_done  = div_done;
endmodule
`default_nettype wire

### hdl/uer_ctrl.sv
// uer_ctrl: handshake and sequencing state machine of the echo ranger
// depends on uer_pkg; commands uer_datapath, owns the result valid flag
`timescale 1ns / 1ps
`default_nettype none
module uer_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire uer_pkg::dp_status_t stat,
  output uer_pkg::ctl_cmd_t        cmd
);
  import uer_pkg::*;

  ctl_state_t state, state_next;
  logic       out_valid_next;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      CTL_IDLE: begin
        if (cmd.tick) begin
          if (stat.needs_div) begin
            state_next = CTL_DIVIDE;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      CTL_DIVIDE: begin
        if (stat.div_done) begin
          state_next     = CTL_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.tick      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_div  = 1'b0;
    unique case (state)
      CTL_IDLE: begin
        // the result register frees up in the same cycle it is taken
        in_ready      = !out_valid || out_ready;
        cmd.tick      = in_valid && in_ready;
        cmd.div_start = cmd.tick && stat.needs_div;
      end
      CTL_DIVIDE: cmd.load_div = stat.div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire
